>>> hdl/vlrs_pkg.sv
// vlrs_pkg: sizes, opcodes and status codes of the variable-length record stack
// no dependencies; imported by the interfaces, the top level and the testbench
`default_nettype none

package vlrs_pkg;

  localparam int STORE_BYTES  = 1024;
  localparam int HEADER_BYTES = 4;
  localparam int MAX_RECORD   = 64;

  // store address, top pointer (holds STORE_BYTES itself) and extended sums
  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int PTR_W  = $clog2(STORE_BYTES + 1);
  localparam int EXT_W  = PTR_W + 1;
  localparam int HC_W   = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

  // fixed field widths
  localparam int OP_W   = 2;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;
  localparam int ST_W   = 2;
  localparam int FREE_W = 11;

  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK  = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

>>> hdl/vlrs_if.sv
// vlrs_in_if / vlrs_out_if: valid-ready channels of the record stack
// depends on vlrs_pkg for field widths
`default_nettype none

interface vlrs_in_if import vlrs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [BYTE_W-1:0] data_byte;
  logic [LEN_W-1:0]  rec_len;
  logic              push_last;

  modport source (output valid, opcode, data_byte, rec_len, push_last, input ready);
  modport sink   (input valid, opcode, data_byte, rec_len, push_last, output ready);
endinterface

interface vlrs_out_if import vlrs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_valid;
  logic              run_last;
  logic              stack_empty;
  logic [FREE_W-1:0] free_bytes;

  modport source (output valid, status, out_byte, byte_valid, run_last, stack_empty,
                  free_bytes, input ready);
  modport sink   (input valid, status, out_byte, byte_valid, run_last, stack_empty,
                  free_bytes, output ready);
endinterface

`default_nettype wire

>>> hdl/vlrs_ram.sv
// vlrs_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module vlrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hdl/variable_length_record_stack.sv
// variable_length_record_stack: byte stack of length-tagged records
// depends on vlrs_pkg, vlrs_in_if / vlrs_out_if and vlrs_ram
//
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    opcode, data_byte, rec_len, push_last
//   out_ch    out   valid/ready    status, out_byte, byte_valid, run_last,
//                                  stack_empty, free_bytes
//
// one item at a time through a small sequencer around a dual-port byte ram
// with registered read; in_ch.ready is high only while the sequencer idles
// push byte: check and store it, on a commit write the header bytes one by
// one, then send the status; clear: send the status; pop/peek: empty check,
// a read and a collect per header byte, then a read and a send per returned
// byte, one ram read per step, or the status alone if the stack is empty or
// no byte is returned; a full output register stalls the sequencer while
// out_ch.ready is low; reset (synchronous, rst_n low) empties the stack,
// no clearing pass since the store content is undefined until written
`default_nettype none

module variable_length_record_stack import vlrs_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  vlrs_in_if.sink   in_ch,
  vlrs_out_if.source out_ch
);

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PUSH = 4'd1;   // check and store one push byte
  localparam logic [3:0] S_HDR  = 4'd2;   // write header bytes of a commit
  localparam logic [3:0] S_POP  = 4'd3;   // empty check for pop/peek
  localparam logic [3:0] S_HRD  = 4'd4;   // issue header byte read
  localparam logic [3:0] S_HACC = 4'd5;   // collect header byte
  localparam logic [3:0] S_RD   = 4'd6;   // issue record byte read
  localparam logic [3:0] S_BYTE = 4'd7;   // send record byte
  localparam logic [3:0] S_EMIT = 4'd8;   // send single status result

  logic [3:0] state_r, state_nxt;

  // latched item
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [BYTE_W-1:0] data_r, data_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              last_r, last_nxt;

  // stack state
  logic [PTR_W-1:0] top_r, top_nxt;
  logic [LEN_W-1:0] off_r, off_nxt;
  logic             rej_r, rej_nxt;

  // working registers
  logic [EXT_W-1:0]  ptr_r, ptr_nxt;     // commit base or next byte address
  logic [HC_W-1:0]   hcnt_r, hcnt_nxt;
  logic [LEN_W-1:0]  bcnt_r, bcnt_nxt;
  logic [LEN_W-1:0]  n_r, n_nxt;         // record length (commit or clamped)
  logic [LEN_W-1:0]  want_r, want_nxt;
  logic [BYTE_W-1:0] b0_r, b0_nxt;       // low header byte
  logic              hi_r, hi_nxt;       // some upper header byte nonzero
  logic [ST_W-1:0]   st_r, st_nxt;
  logic              rd_oor_r, rd_oor_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]   o_status_r, o_status_nxt;
  logic [BYTE_W-1:0] o_byte_r, o_byte_nxt;
  logic              o_bvalid_r, o_bvalid_nxt;
  logic              o_last_r, o_last_nxt;
  logic              o_empty_r, o_empty_nxt;
  logic [FREE_W-1:0] o_free_r, o_free_nxt;

  // ram port
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  logic accept, slot_free;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;

  vlrs_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    logic              first_v;
    logic [EXT_W-1:0]  top_x;
    logic [EXT_W-1:0]  addr_v;
    logic [EXT_W-1:0]  sum_v;
    logic [BYTE_W-1:0] rbyte_v;
    logic [BYTE_W-1:0] b0_v;
    logic              hi_v;
    logic [LEN_W-1:0]  nlen_v;
    logic [LEN_W-1:0]  want_v;

    state_nxt     = state_r;
    op_nxt        = op_r;
    data_nxt      = data_r;
    len_nxt       = len_r;
    last_nxt      = last_r;
    top_nxt       = top_r;
    off_nxt       = off_r;
    rej_nxt       = rej_r;
    ptr_nxt       = ptr_r;
    hcnt_nxt      = hcnt_r;
    bcnt_nxt      = bcnt_r;
    n_nxt         = n_r;
    want_nxt      = want_r;
    b0_nxt        = b0_r;
    hi_nxt        = hi_r;
    st_nxt        = st_r;
    rd_oor_nxt    = rd_oor_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    o_status_nxt  = o_status_r;
    o_byte_nxt    = o_byte_r;
    o_bvalid_nxt  = o_bvalid_r;
    o_last_nxt    = o_last_r;
    o_empty_nxt   = o_empty_r;
    o_free_nxt    = o_free_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    first_v = (off_r == '0) && !rej_r;
    top_x   = EXT_W'(top_r);
    addr_v  = '0;
    sum_v   = '0;
    rbyte_v = rd_oor_r ? '0 : ram_rdata;
    b0_v    = '0;
    hi_v    = 1'b0;
    nlen_v  = '0;
    want_v  = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt   = in_ch.opcode;
          data_nxt = in_ch.data_byte;
          len_nxt  = in_ch.rec_len;
          last_nxt = in_ch.push_last;
          case (in_ch.opcode)
            OP_PUSH: state_nxt = S_PUSH;
            OP_CLEAR: begin
              top_nxt   = PTR_W'(STORE_BYTES);
              off_nxt   = '0;
              rej_nxt   = 1'b0;
              st_nxt    = ST_OK;
              state_nxt = S_EMIT;
            end
            default: begin
              // pop and peek abandon a pending record
              off_nxt   = '0;
              rej_nxt   = 1'b0;
              state_nxt = S_POP;
            end
          endcase
        end
      end

      S_PUSH: begin
        st_nxt    = ST_OK;
        state_nxt = S_EMIT;
        if (rej_r) begin
          st_nxt = ST_FULL;
        end else if (first_v && (len_r > LEN_W'(MAX_RECORD) ||
                     top_x < EXT_W'(len_r) + EXT_W'(HEADER_BYTES))) begin
          st_nxt  = ST_FULL;
          rej_nxt = 1'b1;
        end else if (first_v && len_r == '0) begin
          // empty record commits at once and ends the push
          last_nxt  = 1'b1;
          n_nxt     = '0;
          ptr_nxt   = top_x - EXT_W'(HEADER_BYTES);
          hcnt_nxt  = '0;
          state_nxt = S_HDR;
        end else if (off_r >= LEN_W'(MAX_RECORD) ||
                     top_x < EXT_W'(off_r) + EXT_W'(HEADER_BYTES + 1)) begin
          // extra byte that does not fit
          st_nxt  = ST_FULL;
          rej_nxt = 1'b1;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = ADDR_W'(top_x - EXT_W'(1) - EXT_W'(off_r));
          ram_wdata = data_r;
          off_nxt   = off_r + LEN_W'(1);
          if (last_r) begin
            n_nxt     = off_r + LEN_W'(1);
            ptr_nxt   = top_x - EXT_W'(off_r) - EXT_W'(HEADER_BYTES + 1);
            hcnt_nxt  = '0;
            state_nxt = S_HDR;
          end
        end
        if (last_r || (first_v && !rej_r && len_r == '0 &&
                       len_r <= LEN_W'(MAX_RECORD) &&
                       top_x >= EXT_W'(len_r) + EXT_W'(HEADER_BYTES))) begin
          off_nxt = '0;
          rej_nxt = 1'b0;
        end
      end

      S_HDR: begin
        // little-endian length, only the low byte can be nonzero
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(ptr_r + EXT_W'(hcnt_r));
        ram_wdata = (hcnt_r == '0) ? BYTE_W'(n_r) : '0;
        hcnt_nxt  = hcnt_r + HC_W'(1);
        if (hcnt_r == HC_W'(HEADER_BYTES - 1)) begin
          top_nxt   = PTR_W'(ptr_r);
          state_nxt = S_EMIT;
        end
      end

      S_POP: begin
        if (top_x >= EXT_W'(STORE_BYTES)) begin
          st_nxt    = ST_EMPTY;
          state_nxt = S_EMIT;
        end else begin
          hcnt_nxt  = '0;
          state_nxt = S_HRD;
        end
      end

      S_HRD: begin
        addr_v     = top_x + EXT_W'(hcnt_r);
        ram_re     = 1'b1;
        ram_raddr  = ADDR_W'(addr_v);
        rd_oor_nxt = addr_v >= EXT_W'(STORE_BYTES);
        state_nxt  = S_HACC;
      end

      S_HACC: begin
        b0_v   = (hcnt_r == '0) ? rbyte_v : b0_r;
        hi_v   = (hcnt_r == '0) ? 1'b0 : (hi_r || rbyte_v != '0);
        b0_nxt = b0_v;
        hi_nxt = hi_v;
        if (hcnt_r == HC_W'(HEADER_BYTES - 1)) begin
          nlen_v   = (hi_v || b0_v > BYTE_W'(MAX_RECORD)) ? LEN_W'(MAX_RECORD)
                                                          : LEN_W'(b0_v);
          want_v   = (len_r < nlen_v) ? len_r : nlen_v;
          n_nxt    = nlen_v;
          want_nxt = want_v;
          sum_v    = top_x + EXT_W'(HEADER_BYTES) + EXT_W'(nlen_v);
          if (op_r == OP_POP) begin
            top_nxt = (sum_v > EXT_W'(STORE_BYTES)) ? PTR_W'(STORE_BYTES)
                                                    : PTR_W'(sum_v);
          end
          if (want_v == '0) begin
            st_nxt    = ST_OK;
            state_nxt = S_EMIT;
          end else begin
            // newest byte sits lowest, read from the far end down
            ptr_nxt   = sum_v - EXT_W'(1);
            bcnt_nxt  = '0;
            state_nxt = S_RD;
          end
        end else begin
          hcnt_nxt  = hcnt_r + HC_W'(1);
          state_nxt = S_HRD;
        end
      end

      S_RD: begin
        ram_re     = 1'b1;
        ram_raddr  = ADDR_W'(ptr_r);
        rd_oor_nxt = ptr_r >= EXT_W'(STORE_BYTES);
        state_nxt  = S_BYTE;
      end

      S_BYTE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = ST_OK;
          o_byte_nxt    = rbyte_v;
          o_bvalid_nxt  = 1'b1;
          o_last_nxt    = (bcnt_r + LEN_W'(1)) == want_r;
          o_empty_nxt   = (top_x == EXT_W'(STORE_BYTES));
          o_free_nxt    = FREE_W'(top_r);
          bcnt_nxt      = bcnt_r + LEN_W'(1);
          ptr_nxt       = ptr_r - EXT_W'(1);
          state_nxt     = ((bcnt_r + LEN_W'(1)) == want_r) ? S_IDLE : S_RD;
        end
      end

      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = st_r;
          o_byte_nxt    = '0;
          o_bvalid_nxt  = 1'b0;
          o_last_nxt    = 1'b1;
          o_empty_nxt   = (top_x == EXT_W'(STORE_BYTES));
          o_free_nxt    = FREE_W'(top_r);
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= PTR_W'(STORE_BYTES);
      off_r       <= '0;
      rej_r       <= 1'b0;
      hcnt_r      <= '0;
      bcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      off_r       <= off_nxt;
      rej_r       <= rej_nxt;
      hcnt_r      <= hcnt_nxt;
      bcnt_r      <= bcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    data_r     <= data_nxt;
    len_r      <= len_nxt;
    last_r     <= last_nxt;
    ptr_r      <= ptr_nxt;
    n_r        <= n_nxt;
    want_r     <= want_nxt;
    b0_r       <= b0_nxt;
    hi_r       <= hi_nxt;
    st_r       <= st_nxt;
    rd_oor_r   <= rd_oor_nxt;
    o_status_r <= o_status_nxt;
    o_byte_r   <= o_byte_nxt;
    o_bvalid_r <= o_bvalid_nxt;
    o_last_r   <= o_last_nxt;
    o_empty_r  <= o_empty_nxt;
    o_free_r   <= o_free_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = o_status_r;
  assign out_ch.out_byte    = o_byte_r;
  assign out_ch.byte_valid  = o_bvalid_r;
  assign out_ch.run_last    = o_last_r;
  assign out_ch.stack_empty = o_empty_r;
  assign out_ch.free_bytes  = o_free_r;

  // top pointer never runs past the store
  a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= PTR_W'(STORE_BYTES))
    else $error("top pointer beyond store size");

  // pending record never grows past the largest record
  a_off_range: assert property (@(posedge clk) disable iff (!rst_n)
    off_r <= LEN_W'(MAX_RECORD))
    else $error("push offset beyond largest record");

  // a record byte always carries ok status
  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_bvalid_r |-> o_status_r == ST_OK)
    else $error("record byte with error status");

  // an accepted item always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE)
    else $error("accepted item dropped");

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// testbench: self-checking bench for variable_length_record_stack, one file
// depends on vlrs_pkg, vlrs_in_if / vlrs_out_if and the top level in hdl
// a shadow stack predicts every result; random idling and stalls on both channels

module testbench;
  import vlrs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 200;   // longer than the slowest pop of a full record
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int HOLD_AT     = 40;    // transfers accepted before the hold-off starts
  localparam int QUIET_FROM  = 90;    // window of transfers with no idling at all
  localparam int QUIET_TO    = 140;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  rec_len;
    logic              push_last;
  } stack_cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              run_last;
    logic              stack_empty;
    logic [FREE_W-1:0] free_bytes;
  } stack_result_t;

  logic clk = 1'b0;
  logic rst_n;

  vlrs_in_if  in_ch ();
  vlrs_out_if out_ch ();

  variable_length_record_stack u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // shadow copy of the stack: byte store, top pointer, pending record progress
  logic [BYTE_W-1:0] shadow_store [STORE_BYTES];
  int unsigned       shadow_top;
  int unsigned       shadow_fill;
  bit                shadow_refused;

  stack_cmd_t    cmd_q[$];       // commands waiting for the driver
  stack_result_t result_q[$];    // predicted results, oldest first

  int unsigned queued_cnt;
  int unsigned accepted_cnt;
  int unsigned cycle_cnt;
  int unsigned mismatch_cnt;
  int unsigned hold_left;
  bit          hold_done;
  bit          in_taken;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // write the little-endian length header below the record and move the top down
  function automatic void seal_record(int unsigned len);
    int unsigned base;
    base = shadow_top - len - HEADER_BYTES;
    for (int j = 0; j < HEADER_BYTES; j++) begin
      shadow_store[base + j] = BYTE_W'(len >> (8 * j));
    end
    shadow_top     = base;
    shadow_fill    = 0;
    shadow_refused = 1'b0;
  endfunction

  function automatic void predict_stack_op(stack_cmd_t cmd);
    stack_result_t   step_q[$];
    stack_result_t   r;
    logic [ST_W-1:0] st;
    logic            fin;
    bit              first;
    int unsigned     len;
    int unsigned     want;
    int unsigned     body;
    r   = '0;
    fin = cmd.push_last;
    case (cmd.opcode)
      OP_PUSH: begin
        st    = ST_OK;
        first = (shadow_fill == 0) && !shadow_refused;
        if (shadow_refused) begin
          st = ST_FULL;
        end else if (first && (cmd.rec_len > MAX_RECORD ||
                               shadow_top < cmd.rec_len + HEADER_BYTES)) begin
          // declared length too big or no room for it plus its header
          st             = ST_FULL;
          shadow_refused = 1'b1;
        end else if (first && cmd.rec_len == 0) begin
          // empty record commits at once, whatever push_last says
          seal_record(0);
          fin = 1'b1;
        end else if (shadow_fill >= MAX_RECORD ||
                     shadow_top < shadow_fill + 1 + HEADER_BYTES) begin
          // one byte too many, by the record limit or by the free space
          st             = ST_FULL;
          shadow_refused = 1'b1;
        end else begin
          shadow_store[shadow_top - 1 - shadow_fill] = cmd.data_byte;
          shadow_fill++;
          if (fin) begin
            seal_record(shadow_fill);
          end
        end
        if (fin) begin
          shadow_fill    = 0;
          shadow_refused = 1'b0;
        end
        r.status   = st;
        r.run_last = 1'b1;
        step_q.push_back(r);
      end
      OP_CLEAR: begin
        shadow_fill    = 0;
        shadow_refused = 1'b0;
        shadow_top     = STORE_BYTES;
        r.status       = ST_OK;
        r.run_last     = 1'b1;
        step_q.push_back(r);
      end
      default: begin
        // pop or peek; any pending record is abandoned
        shadow_fill    = 0;
        shadow_refused = 1'b0;
        r.run_last     = 1'b1;
        if (shadow_top >= STORE_BYTES) begin
          r.status = ST_EMPTY;
          step_q.push_back(r);
        end else begin
          len = 0;
          for (int j = 0; j < HEADER_BYTES; j++) begin
            len |= 32'(shadow_store[shadow_top + j]) << (8 * j);
          end
          if (len > MAX_RECORD) begin
            len = MAX_RECORD;
          end
          body = shadow_top + HEADER_BYTES;
          want = (cmd.rec_len < len) ? cmd.rec_len : len;
          r.status = ST_OK;
          if (want == 0) begin
            step_q.push_back(r);
          end else begin
            // bytes come back in record order, the first one stored highest
            for (int unsigned j = 0; j < want; j++) begin
              r.out_byte   = shadow_store[body + len - 1 - j];
              r.byte_valid = 1'b1;
              r.run_last   = (j + 1 == want);
              step_q.push_back(r);
            end
          end
          if (cmd.opcode == OP_POP) begin
            shadow_top = (body + len > STORE_BYTES) ? STORE_BYTES : body + len;
          end
        end
      end
    endcase
    // emptiness and free space reflect the state after the whole step
    foreach (step_q[k]) begin
      step_q[k].stack_empty = (shadow_top == STORE_BYTES);
      step_q[k].free_bytes  = FREE_W'(shadow_top);
      result_q.push_back(step_q[k]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  function automatic void compare_field(string name, int unsigned due, int unsigned got);
    if (due != got) begin
      mismatch_cnt++;
      $display("%0t: %s expected %0d actual %0d", $time, name, due, got);
    end
  endfunction

  function automatic void check_result(stack_result_t got);
    stack_result_t due;
    if (result_q.size() == 0) begin
      mismatch_cnt++;
      $display("%0t: result with nothing expected, expected none actual status %0d byte %0d",
               $time, got.status, got.out_byte);
    end else begin
      due = result_q.pop_front();
      compare_field("status",      due.status,      got.status);
      compare_field("out_byte",    due.out_byte,    got.out_byte);
      compare_field("byte_valid",  due.byte_valid,  got.byte_valid);
      compare_field("run_last",    due.run_last,    got.run_last);
      compare_field("stack_empty", due.stack_empty, got.stack_empty);
      compare_field("free_bytes",  due.free_bytes,  got.free_bytes);
    end
  endfunction

  // monitor: both channels sampled at the rising edge, input side first so a
  // prediction is always in place before its result can show up
  always @(posedge clk) begin : watch_channels
    stack_cmd_t    cmd;
    stack_result_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        cmd.opcode    = in_ch.opcode;
        cmd.data_byte = in_ch.data_byte;
        cmd.rec_len   = in_ch.rec_len;
        cmd.push_last = in_ch.push_last;
        predict_stack_op(cmd);
        in_taken = 1'b1;
        accepted_cnt++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.status      = out_ch.status;
        got.out_byte    = out_ch.out_byte;
        got.byte_valid  = out_ch.byte_valid;
        got.run_last    = out_ch.run_last;
        got.stack_empty = out_ch.stack_empty;
        got.free_bytes  = out_ch.free_bytes;
        check_result(got);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driving, at the falling edge
  // ---------------------------------------------------------------------------

  function automatic bit quiet_window();
    return accepted_cnt >= QUIET_FROM && accepted_cnt < QUIET_TO;
  endfunction

  // command driver: holds an offered item until its transfer, then maybe idles
  always @(negedge clk) begin : drive_commands
    stack_cmd_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      in_taken = 1'b0;
      if (cmd_q.size() != 0 && (quiet_window() || $urandom_range(0, 99) >= 20)) begin
        nxt = cmd_q.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.opcode    <= nxt.opcode;
        in_ch.data_byte <= nxt.data_byte;
        in_ch.rec_len   <= nxt.rec_len;
        in_ch.push_last <= nxt.push_last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls, plus one long hold-off that backs the block up
  always @(negedge clk) begin : drive_ready
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet_window() || $urandom_range(0, 99) >= 20;
    end
  end

  // watchdog
  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("variable_length_record_stack: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic send(logic [OP_W-1:0] op, int unsigned data, int unsigned len, bit fin);
    stack_cmd_t cmd;
    cmd.opcode    = op;
    cmd.data_byte = BYTE_W'(data);
    cmd.rec_len   = LEN_W'(len);
    cmd.push_last = fin;
    cmd_q.push_back(cmd);
    queued_cnt++;
  endtask

  // a record of count push bytes with the given declared length; close marks the end
  task automatic send_record(int unsigned declared, int unsigned count, bit close);
    for (int unsigned j = 0; j < count; j++) begin
      send(OP_PUSH, $urandom, declared, close && (j + 1 == count));
    end
  endtask

  // sender pause: nothing left to offer and every predicted result received
  task automatic wait_drained();
    while (cmd_q.size() != 0 || accepted_cnt != queued_cnt || result_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic random_traffic(int unsigned budget);
    int unsigned base_cnt;
    int unsigned pick;
    int unsigned len;
    base_cnt = queued_cnt;
    while (queued_cnt - base_cnt < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // well-formed record, mostly short
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, MAX_RECORD)
                                          : $urandom_range(0, 6);
        if (len == 0) begin
          send(OP_PUSH, $urandom, 0, 1'($urandom_range(0, 1)));
        end else begin
          send_record(len, len, 1'b1);
        end
      end else if (pick < 48) begin
        // ends early or late against its declared length
        send_record($urandom_range(1, 8), $urandom_range(1, 8), 1'b1);
      end else if (pick < 52) begin
        // declared length over the record limit
        send_record($urandom_range(MAX_RECORD + 1, 127), $urandom_range(1, 3), 1'b1);
      end else if (pick < 60) begin
        // push cut short by a read or a clear
        len = $urandom_range(1, 6);
        send_record(len, $urandom_range(1, len), 1'b0);
        send($urandom_range(0, 9) == 0 ? OP_CLEAR : ($urandom_range(0, 1) ? OP_POP : OP_PEEK),
             $urandom, $urandom_range(0, 127), 1'($urandom_range(0, 1)));
      end else if (pick < 95) begin
        len = $urandom_range(0, 1) ? $urandom_range(0, 127) : $urandom_range(0, 8);
        send(pick < 77 ? OP_PEEK : OP_POP, $urandom, len, 1'($urandom_range(0, 1)));
      end else begin
        send(OP_CLEAR, $urandom, $urandom_range(0, 127), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin : stimulus
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.opcode    = OP_PUSH;
    in_ch.data_byte = '0;
    in_ch.rec_len   = '0;
    in_ch.push_last = 1'b0;
    out_ch.ready    = 1'b0;
    for (int j = 0; j < STORE_BYTES; j++) begin
      shadow_store[j] = '0;
    end
    shadow_top     = STORE_BYTES;
    shadow_fill    = 0;
    shadow_refused = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reads on an empty stack
    send(OP_POP,  8'hFF, 127, 1'b1);
    send(OP_PEEK, 8'h00, 0,   1'b0);
    // empty record with push_last low, then read it back and drop it
    send(OP_PUSH, 8'hFF, 0, 1'b0);
    send(OP_PEEK, 8'h00, 5, 1'b0);
    send(OP_POP,  8'h00, 5, 1'b1);
    // three-byte record with extreme data values
    send(OP_PUSH, 8'h00, 3, 1'b0);
    send(OP_PUSH, 8'hFF, 3, 1'b0);
    send(OP_PUSH, 8'hA5, 3, 1'b1);
    send(OP_PEEK, 8'h00, 0,   1'b0);   // zero bytes wanted
    send(OP_PEEK, 8'h00, 2,   1'b0);   // truncated read
    send(OP_POP,  8'h00, 127, 1'b0);
    // oversize declared length: every item up to the end reports full
    send(OP_PUSH, 8'h11, 127, 1'b0);
    send(OP_PUSH, 8'h22, 127, 1'b1);
    // early end, then late end
    send_record(4, 2, 1'b1);
    send_record(1, 3, 1'b1);
    // pending record abandoned by a peek
    send_record(5, 2, 1'b0);
    send(OP_PEEK, 8'h00, 127, 1'b1);
    send(OP_CLEAR, 8'hFF, 127, 1'b1);
    send(OP_POP,   8'h00, 1,   1'b0);
    wait_drained();

    random_traffic(30);
    wait_drained();

    // record limit: one byte past it, then a record of exactly the limit
    send(OP_CLEAR, 8'h00, 0, 1'b0);
    send_record(MAX_RECORD, MAX_RECORD + 1, 1'b1);
    send_record(MAX_RECORD, MAX_RECORD, 1'b1);
    send(OP_PEEK, 8'h00, 127, 1'b0);
    send(OP_POP,  8'h00, MAX_RECORD, 1'b0);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0 && result_q.size() == 0) begin
      $display("variable_length_record_stack: match");
    end else begin
      $display("variable_length_record_stack: mismatch");
    end
    $finish;
  end

endmodule
